/* hw/rtl/mls_sliding_correlator_macros.svh */
// Assertion macros for the checker file of the sliding correlator.
`ifndef MLS_SLIDING_CORRELATOR_MACROS_SVH
`define MLS_SLIDING_CORRELATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MLSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Correlator port check failed.");

// Next-cycle implication, disabled while reset is high.
`define MLSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Correlator port check failed.");

`endif

/* hw/rtl/mlsc_pkg.sv */
// Shared types, constants and register codes for the m-sequence sliding correlator.
package mlsc_pkg;

   // Sequence length and datapath widths.
   localparam int DEGREE     = 10;
   localparam int SEQ_LEN    = (1 << DEGREE) - 1;
   localparam int LFSR_W     = 10;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = SAMPLE_W + DEGREE;
   localparam int FRAC_W     = 32;
   localparam int RECIP_W    = 33 - DEGREE;
   localparam int PROD_W     = SUM_W + RECIP_W + 1;
   localparam int QUOT_W     = PROD_W - FRAC_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = LFSR_W;

   // Reciprocal of the sequence length with 32 fractional bits, rounded to nearest.
   localparam longint unsigned RECIP = ((64'd1 << FRAC_W) + SEQ_LEN / 2) / SEQ_LEN;

   // Register reset values.
   localparam logic [LFSR_W-1:0] MASK_RESET = LFSR_W'(576);
   localparam logic [LFSR_W-1:0] SEED_RESET = LFSR_W'(1);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LFSR_MASK = 1'b0,
      CSR_LFSR_SEED = 1'b1
   } csr_index_type;

   // One complex input sample; also the contents of one window cell.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
   } req_payload_type;

   // One normalized complex correlation result.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] corr_re;
      logic signed [SAMPLE_W-1:0] corr_im;
   } rsp_payload_type;

   // Controls for the sample ring.
   typedef struct packed {
      logic shift;
      logic load_new;
   } chain_ctrl_type;

   // Controls for the chip generator.
   typedef struct packed {
      logic load;
      logic step;
   } lfsr_ctrl_type;

endpackage

/* hw/rtl/mlsc_cell.sv */
// One window cell: holds a complex sample and takes its neighbor's value on a shift.
module mlsc_cell
   import mlsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  req_payload_type sample_in,
   output req_payload_type sample_out
);

   req_payload_type sample_ff;

   // The window starts out all zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (enable) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

/* hw/rtl/mlsc_chain.sv */
// Ring of window cells: shifts a new sample in, or rotates the window past its head.
module mlsc_chain
   import mlsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  chain_ctrl_type  ctrl,
   input  req_payload_type new_sample,
   output req_payload_type head_sample
);

   req_payload_type tap [SEQ_LEN];
   req_payload_type tail_in;

   // The last cell takes the new sample on a request, else the head sample wraps around.
   assign tail_in = ctrl.load_new ? new_sample : tap[0];

   // Cell k holds window entry k; cell 0 is the oldest sample.
   for (genvar k = 0; k < SEQ_LEN; k++) begin : g_cell
      if (k == SEQ_LEN - 1) begin : g_tail
         mlsc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .enable     (ctrl.shift),
            .sample_in  (tail_in),
            .sample_out (tap[k])
         );
      end else begin : g_body
         mlsc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .enable     (ctrl.shift),
            .sample_in  (tap[k+1]),
            .sample_out (tap[k])
         );
      end
   end

   assign head_sample = tap[0];

endmodule

/* hw/rtl/mlsc_lfsr.sv */
// Galois LFSR that regenerates the reference chips, one chip per step.
module mlsc_lfsr
   import mlsc_pkg::*;
(
   input  logic              clock,
   input  lfsr_ctrl_type     ctrl,
   input  logic [LFSR_W-1:0] mask,
   input  logic [LFSR_W-1:0] seed,
   output logic              chip
);

   logic [LFSR_W-1:0] state_ff;
   logic [LFSR_W-1:0] state_in;

   // Emit the low bit, shift right, and fold in the mask when that bit was one.
   always_comb begin
      state_in = state_ff;
      if (ctrl.load) begin
         state_in = seed;
      end else if (ctrl.step) begin
         state_in = (state_ff >> 1) ^ (state_ff[0] ? mask : '0);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign chip = state_ff[0];

endmodule

/* hw/rtl/mlsc_scale.sv */
// Scaling by 1/L: registered multiply by the reciprocal, then rounding and saturation.
module mlsc_scale
   import mlsc_pkg::*;
(
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [SUM_W-1:0] sum_re,
   input  logic signed [SUM_W-1:0] sum_im,
   output rsp_payload_type         scaled
);

   localparam logic signed [RECIP_W:0]    RECIP_S    = {1'b0, RECIP_W'(RECIP)};
   localparam logic signed [PROD_W-1:0]   ROUND_HALF =
      {{(QUOT_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
   localparam logic signed [QUOT_W-1:0]   QUOT_MAX   = QUOT_W'((1 << (SAMPLE_W-1)) - 1);
   localparam logic signed [QUOT_W-1:0]   QUOT_MIN   = QUOT_W'(-(1 << (SAMPLE_W-1)));

   logic signed [PROD_W-1:0] prod_re_ff;
   logic signed [PROD_W-1:0] prod_im_ff;
   logic signed [PROD_W-1:0] prod_re_in;
   logic signed [PROD_W-1:0] prod_im_in;

   // Round to nearest with ties upward, then clamp to the 16-bit range.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] biased;
      logic signed [QUOT_W-1:0] quot;
      biased = prod + ROUND_HALF;
      quot   = biased[PROD_W-1:FRAC_W];
      if (quot > QUOT_MAX) begin
         return QUOT_MAX[SAMPLE_W-1:0];
      end else if (quot < QUOT_MIN) begin
         return QUOT_MIN[SAMPLE_W-1:0];
      end
      return quot[SAMPLE_W-1:0];
   endfunction

   // Exact products of the sums and the fixed-point reciprocal.
   assign prod_re_in = PROD_W'(sum_re) * PROD_W'(RECIP_S);
   assign prod_im_in = PROD_W'(sum_im) * PROD_W'(RECIP_S);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
   end

   assign scaled.corr_re = round_sat(prod_re_ff);
   assign scaled.corr_im = round_sat(prod_im_ff);

endmodule

/* hw/rtl/mls_sliding_correlator.sv */
// Top level of the m-sequence sliding correlator: control, accumulator and ports.
//
//   Channel   Direction   Handshake                Payload
//   req       in          req_valid / req_stall    req_payload (sample_re, sample_im)
//   rsp       out         rsp_valid / rsp_stall    rsp_payload (corr_re, corr_im)
//   csr       in          csr_we                   csr_index, csr_wdata
//
// Each request first shifts its sample in; the single accumulator then walks the window
// ring one cell a cycle; the sum is then multiplied, and the product is rounded into the
// output register.
// Reset is synchronous; the window cells clear in the same cycle, with no clearing pass.
// The next request is taken as soon as the output register holds the previous result.
// A stalled result holds the block in its last step until the output register frees up.
module mls_sliding_correlator
   import mlsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_MUL,
      ST_OUT
   } state_type;

   localparam logic [DEGREE-1:0] COUNT_LAST = DEGREE'(SEQ_LEN - 1);

   state_type               state_ff;
   logic [DEGREE-1:0]       count_ff;
   logic signed [SUM_W-1:0] acc_re_ff;
   logic signed [SUM_W-1:0] acc_im_ff;
   logic signed [SUM_W-1:0] acc_re_in;
   logic signed [SUM_W-1:0] acc_im_in;
   logic signed [SUM_W-1:0] term_re;
   logic signed [SUM_W-1:0] term_im;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;
   logic [LFSR_W-1:0]       mask_ff;
   logic [LFSR_W-1:0]       seed_ff;

   logic            req_accept;
   logic            out_free;
   logic            chip;
   chain_ctrl_type  chain_ctrl;
   lfsr_ctrl_type   lfsr_ctrl;
   req_payload_type head_sample;
   rsp_payload_type scaled;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
         seed_ff <= SEED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LFSR_MASK: mask_ff <= csr_wdata;
            CSR_LFSR_SEED: seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake decode.
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // The ring shifts a new sample in on a request and rotates once per accumulate cycle.
   assign chain_ctrl.shift    = req_accept || (state_ff == ST_ACC);
   assign chain_ctrl.load_new = req_accept;

   // The chip generator restarts from the seed on each request.
   assign lfsr_ctrl.load = req_accept;
   assign lfsr_ctrl.step = (state_ff == ST_ACC);

   // Add or subtract the head sample according to the current chip.
   assign term_re   = chip ? SUM_W'(head_sample.sample_re) : -SUM_W'(head_sample.sample_re);
   assign term_im   = chip ? SUM_W'(head_sample.sample_im) : -SUM_W'(head_sample.sample_im);
   assign acc_re_in = acc_re_ff + term_re;
   assign acc_im_in = acc_im_ff + term_im;

   mlsc_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (chain_ctrl),
      .new_sample  (req_payload),
      .head_sample (head_sample)
   );

   mlsc_lfsr u_lfsr (
      .clock (clock),
      .ctrl  (lfsr_ctrl),
      .mask  (mask_ff),
      .seed  (seed_ff),
      .chip  (chip)
   );

   mlsc_scale u_scale (
      .clock  (clock),
      .load   (state_ff == ST_MUL),
      .sum_re (acc_re_ff),
      .sum_im (acc_im_ff),
      .scaled (scaled)
   );

   // Sequencer with the accumulator and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output register empties when its result is taken, unless a new one moves in.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  acc_re_ff <= '0;
                  acc_im_ff <= '0;
                  count_ff  <= '0;
                  state_ff  <= ST_ACC;
               end
            end
            ST_ACC: begin
               acc_re_ff <= acc_re_in;
               acc_im_ff <= acc_im_in;
               count_ff  <= count_ff + 1'b1;
               if (count_ff == COUNT_LAST) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_payload_ff <= scaled;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hw/rtl/mlsc_checker.sv */
// Port-level checks for the sliding correlator, bound to its top level.
`include "mls_sliding_correlator_macros.svh"

module mlsc_checker
   import mlsc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_payload
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   // A request keeps the block busy for the following cycle.
   `MLSC_ASSERT_NXT(a_busy_after_request, clock, reset, req_accept, req_stall)

   // A result never shows up in the cycle right after its request.
   `MLSC_ASSERT_NXT(a_no_early_response, clock, reset, req_accept, !$rose(rsp_valid))

   // A new result only appears at the end of work in progress.
   `MLSC_ASSERT_IMP(a_response_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // A stalled result stays put.
   `MLSC_ASSERT_NXT(a_response_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind mls_sliding_correlator mlsc_checker u_mlsc_checker (.*);
